[hdl/assert_macros.svh]
// Assertion macros for the selective-repeat receiver RTL, used by srr_ctrl.
// Every use expects clk_i and rst_ni to be in scope of the asserting module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset.
`define SRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define SRR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hdl/srr_pkg.sv]
// Package of the selective-repeat receiver: state encoding, result kinds
// and fixed constants. It depends on nothing else.
package srr_pkg;

  // Widths that the interface fixes.
  localparam int SEQ_BITS  = 3;
  localparam int WIN_BITS  = 3;
  localparam int OUT_BITS  = 64;
  localparam int CNT_BITS  = 3;

  // At most this many deliveries follow one acknowledgement.
  localparam int MAX_DELIVER = 7;

  localparam logic [WIN_BITS-1:0] WINDOW_SIZE_RESET = 3'd4;

  // Result kinds.
  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_DLV = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACK,
    ST_RD,
    ST_DLV
  } state_e;

endpackage

[hdl/srr_store.sv]
// Payload store with no reset: one write and one read port, read data registered.
// Uses no other file; users read an entry only after it is written, not enforced.
module srr_store #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered, old data on a same-address write.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/srr_ctrl.sv]
// Sequencer of the selective-repeat receiver: window check, held marks, base,
// delivery burst and the output register. Uses srr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srr_ctrl #(
  parameter int SEQ_SPACE    = 8,
  parameter int PAYLOAD_BITS = 64,
  localparam int IDX_W = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Packet channel.
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [srr_pkg::SEQ_BITS-1:0]     seq_number_i,
  input  logic                             checksum_ok_i,
  input  logic [PAYLOAD_BITS-1:0]          payload_i,
  // Window size register.
  input  logic [srr_pkg::WIN_BITS-1:0]     win_size_i,
  // Payload store.
  output logic                             mem_we_o,
  output logic [IDX_W-1:0]                 mem_waddr_o,
  output logic [PAYLOAD_BITS-1:0]          mem_wdata_o,
  output logic [IDX_W-1:0]                 mem_raddr_o,
  input  logic [PAYLOAD_BITS-1:0]          mem_rdata_i,
  // Result channel.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             kind_o,
  output logic [srr_pkg::SEQ_BITS-1:0]     ack_number_o,
  output logic [srr_pkg::OUT_BITS-1:0]     delivered_payload_o,
  output logic                             last_o
);

  // Wide enough for a sequence number, a base and the space size itself.
  localparam int CMP_W = ((IDX_W > srr_pkg::SEQ_BITS) ? IDX_W : srr_pkg::SEQ_BITS) + 1;

  srr_pkg::state_e state_q, state_d;

  logic [srr_pkg::SEQ_BITS-1:0] seq_q;
  logic [PAYLOAD_BITS-1:0]      pay_q;
  logic [IDX_W-1:0]             base_q, base_d, base_next;
  logic [SEQ_SPACE-1:0]         held_q, held_d;
  logic [srr_pkg::CNT_BITS-1:0] cnt_q, cnt_d;

  logic                         out_valid_q, out_valid_d;
  logic                         out_kind_q;
  logic [srr_pkg::SEQ_BITS-1:0] out_ack_q;
  logic [srr_pkg::OUT_BITS-1:0] out_data_q;
  logic                         out_last_q;

  logic                         in_accept;
  logic                         out_free;
  logic                         emit;
  logic                         dlv_emit;
  logic                         e_kind;
  logic [srr_pkg::SEQ_BITS-1:0] e_ack;
  logic [srr_pkg::OUT_BITS-1:0] e_data;
  logic                         e_last;

  logic [CMP_W-1:0]             seq_ext, base_ext, offset;
  logic [IDX_W-1:0]             seq_idx;
  logic                         in_win;

  assign in_stall_o = (state_q != srr_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign base_next = (base_q == IDX_W'(SEQ_SPACE - 1)) ? '0 : base_q + 1'b1;

  // Window check: circular distance from the base, compared to the window size; numbers beyond the space are out.
  always_comb begin
    seq_ext = CMP_W'(seq_q);
    base_ext = CMP_W'(base_q);
    seq_idx = IDX_W'(seq_q);
    offset = seq_ext - base_ext;
    if (seq_ext < base_ext) begin
      offset = offset + CMP_W'(SEQ_SPACE);
    end
    in_win = (seq_ext < CMP_W'(SEQ_SPACE)) && (offset < CMP_W'(win_size_i));
  end

  // Next state, held marks, base and the result to load.
  always_comb begin
    state_d = state_q;
    held_d = held_q;
    base_d = base_q;
    cnt_d = cnt_q;
    emit = 1'b0;
    dlv_emit = 1'b0;
    e_kind = srr_pkg::KIND_ACK;
    e_ack = seq_q;
    e_data = '0;
    e_last = 1'b1;
    mem_we_o = 1'b0;
    mem_raddr_o = base_q;
    case (state_q)
      srr_pkg::ST_IDLE: begin
        if (in_accept && checksum_ok_i) begin
          state_d = srr_pkg::ST_ACK;
        end
      end
      srr_pkg::ST_ACK: begin
        // A delivery follows when the packet is in the window and the base entry is held after this write.
        e_last = !(in_win && (held_q[base_q] || (seq_idx == base_q)));
        if (out_free) begin
          emit = 1'b1;
          cnt_d = '0;
          if (in_win) begin
            mem_we_o = 1'b1;
            held_d[seq_idx] = 1'b1;
          end
          state_d = e_last ? srr_pkg::ST_IDLE : srr_pkg::ST_RD;
        end
      end
      srr_pkg::ST_RD: begin
        // The base entry is read after any write of the acknowledge cycle.
        state_d = srr_pkg::ST_DLV;
      end
      srr_pkg::ST_DLV: begin
        e_kind = srr_pkg::KIND_DLV;
        e_ack = '0;
        e_data = srr_pkg::OUT_BITS'(mem_rdata_i);
        e_last = (cnt_q == srr_pkg::CNT_BITS'(srr_pkg::MAX_DELIVER - 1)) ||
                 !held_q[base_next];
        if (out_free) begin
          emit = 1'b1;
          dlv_emit = 1'b1;
          held_d[base_q] = 1'b0;
          base_d = base_next;
          cnt_d = cnt_q + 1'b1;
          mem_raddr_o = base_next;
          state_d = e_last ? srr_pkg::ST_IDLE : srr_pkg::ST_DLV;
        end
      end
      default: begin
        state_d = srr_pkg::ST_IDLE;
      end
    endcase
  end

  assign mem_waddr_o = seq_idx;
  assign mem_wdata_o = pay_q;
  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srr_pkg::ST_IDLE;
      base_q <= '0;
      held_q <= '0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q <= base_d;
      held_q <= held_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Packet capture and the output register payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      seq_q <= seq_number_i;
      pay_q <= payload_i;
    end
    if (emit) begin
      out_kind_q <= e_kind;
      out_ack_q <= e_ack;
      out_data_q <= e_data;
      out_last_q <= e_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o = out_kind_q;
  assign ack_number_o = out_ack_q;
  assign delivered_payload_o = out_data_q;
  assign last_o = out_last_q;

  // Checks on the delivery sequencing.
  `SRR_ASSERT_IMPL(a_dlv_from_held, dlv_emit, held_q[base_q], "delivery of an entry not held")
  `SRR_ASSERT_IMPL(a_base_moves_on_dlv, base_q != $past(base_q), $past(dlv_emit), "base moved without delivery")
  `SRR_ASSERT(a_burst_bound, (state_q != srr_pkg::ST_DLV) || (cnt_q < srr_pkg::CNT_BITS'(srr_pkg::MAX_DELIVER)), "delivery burst too long")

endmodule

[hdl/selective_repeat_receiver_top.sv]
// Top level of the selective-repeat receiver: window size register,
// sequencer and payload store. Uses srr_pkg, srr_ctrl and srr_store.

// One packet per transfer. A corrupt packet is taken and gives nothing. A
// good packet passes through an acknowledge state, which loads its
// acknowledgement into the output register; if it lets n held payloads go
// out in order (n up to seven), a read state follows and then one delivery
// per cycle while the result side does not stall. The single read port of
// the payload store paces the delivery burst. The last result of each good
// packet carries last. Payload bits above PAYLOAD_BITS are dropped, and
// sequence numbers at or beyond SEQ_SPACE are only acknowledged. The window
// size may be written only while idle.
module selective_repeat_receiver_top #(
  parameter int SEQ_SPACE    = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [srr_pkg::SEQ_BITS-1:0] seq_number_i,
  input  logic                         checksum_ok_i,
  input  logic [srr_pkg::OUT_BITS-1:0] payload_i,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         kind_o,
  output logic [srr_pkg::SEQ_BITS-1:0] ack_number_o,
  output logic [srr_pkg::OUT_BITS-1:0] delivered_payload_o,
  output logic                         last_o,
  input  logic                         cfg_we_i,
  input  logic [srr_pkg::WIN_BITS-1:0] cfg_wdata_i
);

  localparam int IDX_W = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;

  logic [srr_pkg::WIN_BITS-1:0] win_size_q;
  logic                         mem_we;
  logic [IDX_W-1:0]             mem_waddr, mem_raddr;
  logic [PAYLOAD_BITS-1:0]      mem_wdata, mem_rdata;

  // Window size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= srr_pkg::WINDOW_SIZE_RESET;
    end else if (cfg_we_i) begin
      win_size_q <= cfg_wdata_i;
    end
  end

  srr_ctrl #(
    .SEQ_SPACE   (SEQ_SPACE),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .seq_number_i       (seq_number_i),
    .checksum_ok_i      (checksum_ok_i),
    .payload_i          (payload_i[PAYLOAD_BITS-1:0]),
    .win_size_i         (win_size_q),
    .mem_we_o           (mem_we),
    .mem_waddr_o        (mem_waddr),
    .mem_wdata_o        (mem_wdata),
    .mem_raddr_o        (mem_raddr),
    .mem_rdata_i        (mem_rdata),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .kind_o             (kind_o),
    .ack_number_o       (ack_number_o),
    .delivered_payload_o(delivered_payload_o),
    .last_o             (last_o)
  );

  srr_store #(
    .DEPTH(SEQ_SPACE),
    .WIDTH(PAYLOAD_BITS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule
